@@ hdl/kfd_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypoint frame deframer package
// Shared constants, register codes and the status word passed from the
// frame synchroniser to the top level.
// ----------------------------------------------------------------------------
package kfd_pkg;

    // Width of one received byte and of one configuration register.
    localparam int BYTE_W          = 8;
    // Bytes carried by one keypoint: three little-endian 16-bit coordinates.
    localparam int BYTES_PER_POINT = 6;
    localparam int POINT_W         = BYTES_PER_POINT * BYTE_W;
    localparam int COORD_W         = 16;
    // The point index on the result port wraps at four.
    localparam int POINT_IDX_W     = 2;
    // Default keypoint count per frame.
    localparam int NUM_POINTS_DEF  = 4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER = 1'b0,
        CFG_FOOTER = 1'b1
    } cfg_reg_t;

    // Status from the frame synchroniser.
    typedef struct packed {
        logic at_footer;  // the next byte taken is the footer
        logic frame_ok;   // a matching footer byte is taken in this cycle
    } sync_stat_t;

endpackage

@@ hdl/keypoint_frame_deframer_core.sv @@
// ----------------------------------------------------------------------------
// Keypoint frame deframer core
// Finds fixed-length header/footer frames in a byte stream and emits one
// word per keypoint with three signed 16-bit coordinates.
// ----------------------------------------------------------------------------
// Output: a good footer byte loads the keypoint buffer, and the first word then
// moves from the buffer into the output word register once that register is free;
// the remaining words follow one a cycle while the output flows.
// Throughput: one byte a cycle. The input stalls only at a footer byte while
// the keypoint buffer of the previous frame still holds words to send.
// Reset: hunting for a header, both configuration registers zero, no output.
// ----------------------------------------------------------------------------
module keypoint_frame_deframer_core #(
    parameter int NUM_POINTS = kfd_pkg::NUM_POINTS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // Configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [kfd_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [kfd_pkg::BYTE_W-1:0]              cfg_wr_data,
    // Byte input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [kfd_pkg::BYTE_W-1:0]              rx_byte,
    // Keypoint output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [kfd_pkg::POINT_IDX_W-1:0]         point_index,
    output logic signed [kfd_pkg::COORD_W-1:0]      coord_x,
    output logic signed [kfd_pkg::COORD_W-1:0]      coord_y,
    output logic signed [kfd_pkg::COORD_W-1:0]      coord_z,
    output logic                                    last_point
);
    import kfd_pkg::*;

    localparam int LEFT_W = $clog2(NUM_POINTS + 1);

    logic [BYTE_W-1:0]             header_reg;
    logic [BYTE_W-1:0]             footer_reg;
    logic                          in_take;
    logic [POINT_W*NUM_POINTS-1:0] payload;
    sync_stat_t                    sync_stat;

    logic [POINT_W-1:0]            row_reg [0:NUM_POINTS-1];
    logic [LEFT_W-1:0]             emit_left_reg;
    logic [POINT_IDX_W-1:0]        point_cnt_reg;
    logic                          out_load;

    logic                          out_valid_reg;
    logic [POINT_IDX_W-1:0]        point_index_reg;
    logic signed [COORD_W-1:0]     coord_x_reg;
    logic signed [COORD_W-1:0]     coord_y_reg;
    logic signed [COORD_W-1:0]     coord_z_reg;
    logic                          last_point_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            footer_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_HEADER: header_reg <= cfg_wr_data;
                CFG_FOOTER: footer_reg <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // A footer waits while the keypoint buffer is still busy.
    assign in_stall = sync_stat.at_footer && (emit_left_reg != '0);
    assign in_take  = in_valid && !in_stall;

    kfd_frame_sync #(
        .NUM_POINTS (NUM_POINTS)
    ) u_sync (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_take     (in_take),
        .rx_byte     (rx_byte),
        .header_byte (header_reg),
        .footer_byte (footer_reg),
        .payload     (payload),
        .stat        (sync_stat)
    );

    // Keypoint buffer: loaded whole on a good footer, shifted one row per word.
    assign out_load = (emit_left_reg != '0) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_left_reg <= '0;
            point_cnt_reg <= '0;
        end
        else if (sync_stat.frame_ok)
        begin
            emit_left_reg <= LEFT_W'(NUM_POINTS);
            point_cnt_reg <= '0;
        end
        else if (out_load)
        begin
            emit_left_reg <= emit_left_reg - LEFT_W'(1);
            point_cnt_reg <= point_cnt_reg + POINT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sync_stat.frame_ok)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                row_reg[i] <= payload[i*POINT_W +: POINT_W];
            end
        end
        else if (out_load)
        begin
            for (int i = 0; i < NUM_POINTS - 1; i++)
            begin
                row_reg[i] <= row_reg[i+1];
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            point_index_reg <= point_cnt_reg;
            coord_x_reg     <= signed'(row_reg[0][0*COORD_W +: COORD_W]);
            coord_y_reg     <= signed'(row_reg[0][1*COORD_W +: COORD_W]);
            coord_z_reg     <= signed'(row_reg[0][2*COORD_W +: COORD_W]);
            last_point_reg  <= (emit_left_reg == LEFT_W'(1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_index = point_index_reg;
    assign coord_x     = coord_x_reg;
    assign coord_y     = coord_y_reg;
    assign coord_z     = coord_z_reg;
    assign last_point  = last_point_reg;

    // A good frame never overwrites words that are still to be sent.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        sync_stat.frame_ok |-> (emit_left_reg == '0))
        else $error("good frame arrived while keypoint buffer busy");

    // A good frame queues exactly one word per keypoint.
    a_frame_load: assert property (@(posedge clk) disable iff (!rst_n)
        sync_stat.frame_ok |=> (emit_left_reg == LEFT_W'(NUM_POINTS)))
        else $error("keypoint count not loaded after good frame");

    // The first word of a frame carries point index zero.
    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (emit_left_reg == LEFT_W'(NUM_POINTS)))
        |=> (point_index_reg == '0))
        else $error("first keypoint word has non-zero index");

endmodule

@@ hdl/kfd_frame_sync.sv @@
// ----------------------------------------------------------------------------
// Keypoint frame synchroniser
// Hunts for the header byte, shifts the payload bytes of a frame into a
// shift line and checks the footer byte.
// ----------------------------------------------------------------------------
module kfd_frame_sync #(
    parameter int NUM_POINTS = kfd_pkg::NUM_POINTS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_take,
    input  logic [kfd_pkg::BYTE_W-1:0]                       rx_byte,
    input  logic [kfd_pkg::BYTE_W-1:0]                       header_byte,
    input  logic [kfd_pkg::BYTE_W-1:0]                       footer_byte,
    output logic [kfd_pkg::POINT_W*NUM_POINTS-1:0]           payload,
    output kfd_pkg::sync_stat_t                              stat
);
    import kfd_pkg::*;

    localparam int PAYLOAD_LEN = BYTES_PER_POINT * NUM_POINTS;
    localparam int POS_W       = $clog2(PAYLOAD_LEN + 1);

    logic              in_frame_reg;
    logic              in_frame_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] store_reg [0:PAYLOAD_LEN-1];
    logic              payload_take;

    // The footer position is reached once the whole payload is in.
    assign stat.at_footer = in_frame_reg && (pos_reg == POS_W'(PAYLOAD_LEN));
    assign stat.frame_ok  = in_take && stat.at_footer && (rx_byte == footer_byte);
    assign payload_take   = in_take && in_frame_reg && !stat.at_footer;

    // Hunting and byte position control.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        if (in_take)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == header_byte)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = '0;
                end
            end
            else if (stat.at_footer)
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
        end
    end

    // Payload shift line: after a full payload, entry k holds byte k.
    always_ff @(posedge clk)
    begin
        if (payload_take)
        begin
            store_reg[PAYLOAD_LEN-1] <= rx_byte;
            for (int k = 0; k < PAYLOAD_LEN - 1; k++)
            begin
                store_reg[k] <= store_reg[k+1];
            end
        end
    end

    // Flatten the payload, byte 0 in the lowest bits.
    always_comb
    begin
        for (int k = 0; k < PAYLOAD_LEN; k++)
        begin
            payload[k*BYTE_W +: BYTE_W] = store_reg[k];
        end
    end

endmodule

@@ tb/tb_keypoint_frame_deframer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypoint frame deframer core testbench
// Feeds header/footer byte frames, noise and broken frames into the
// deframer under several header and footer settings and idling patterns.
// A scoreboard class tracks the frame synchroniser state and checks every
// keypoint word on the output, field by field, in order.
// ----------------------------------------------------------------------------
module tb_keypoint_frame_deframer_core;

    import kfd_pkg::*;

    localparam int NUM_POINTS     = NUM_POINTS_DEF;
    localparam int PAYLOAD_LEN    = BYTES_PER_POINT * NUM_POINTS;
    // Extra wait after the last expected word has been taken.
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    // Each random phase runs until at least this many bytes are taken.
    localparam int RANDOM_BYTES   = 1;

    // One keypoint word as seen on the output channel.
    typedef struct {
        logic [POINT_IDX_W-1:0]    idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } kp_word_t;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the frame synchroniser and queues the keypoint
    // words that each accepted footer releases.
    // ------------------------------------------------------------------------
    class keypoint_scoreboard;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] ftr;
        bit                in_frame;
        int                pos;
        logic [BYTE_W-1:0] store [PAYLOAD_LEN];
        kp_word_t          pending_points [$];
        int                errors;
        int                bytes_in;
        int                words_out;
        int                frames_ok;
        int                frames_dropped;

        function new();
            hdr            = '0;
            ftr            = '0;
            in_frame       = 0;
            pos            = 0;
            errors         = 0;
            bytes_in       = 0;
            words_out      = 0;
            frames_ok      = 0;
            frames_dropped = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [BYTE_W-1:0] v);
            if (idx == CFG_HEADER)
                hdr = v;
            else
                ftr = v;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        // Advance the frame state by one accepted byte.
        function void take_byte(logic [BYTE_W-1:0] b);
            kp_word_t w;
            int       base;
            bytes_in++;
            if (!in_frame) begin
                if (b == hdr) begin
                    in_frame = 1;
                    pos      = 0;
                end
                return;
            end
            // A header value inside the frame is just payload.
            if (pos < PAYLOAD_LEN) begin
                store[pos] = b;
                pos++;
                return;
            end
            // Footer position: back to hunting whatever the footer holds.
            in_frame = 0;
            pos      = 0;
            if (b != ftr) begin
                frames_dropped++;
                return;
            end
            frames_ok++;
            for (int p = 0; p < NUM_POINTS; p++) begin
                base   = p * BYTES_PER_POINT;
                w.idx  = p[POINT_IDX_W-1:0];
                w.x    = {store[base + 1], store[base + 0]};
                w.y    = {store[base + 3], store[base + 2]};
                w.z    = {store[base + 5], store[base + 4]};
                w.last = (p == NUM_POINTS - 1);
                pending_points.push_back(w);
            end
        endfunction

        // Compare one output word with the oldest expected word.
        function void check_word(kp_word_t got);
            kp_word_t want;
            words_out++;
            if (pending_points.size() == 0) begin
                $error("unexpected keypoint word: index %0d x %0d y %0d z %0d last %0b",
                       got.idx, got.x, got.y, got.z, got.last);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            if (got.idx !== want.idx) begin
                $error("point_index: expected %0d, got %0d", want.idx, got.idx);
                errors++;
            end
            if (got.x !== want.x) begin
                $error("coord_x: expected %0d, got %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("coord_y: expected %0d, got %0d", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $error("coord_z: expected %0d, got %0d", want.z, got.z);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_point: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    cfg_reg_t                  cfg_index;
    logic [BYTE_W-1:0]         cfg_wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [BYTE_W-1:0]         rx_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic [POINT_IDX_W-1:0]    point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;

    keypoint_scoreboard sb = new();
    kp_word_t           seen_word;
    logic [BYTE_W-1:0]  frame_payload [PAYLOAD_LEN];
    int                 idle_pct   = 0;
    int                 stall_pct  = 0;
    int                 quiet_cycles = 0;
    int                 phases_run = 0;

    keypoint_frame_deframer_core #(
        .NUM_POINTS (NUM_POINTS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .last_point  (last_point)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Output monitor: check each word taken at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_word.idx  = point_index;
            seen_word.x    = coord_x;
            seen_word.y    = coord_y;
            seen_word.z    = coord_z;
            seen_word.last = last_point;
            sb.check_word(seen_word);
        end
    end

    // Watchdog: the run ends if neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("** keypoint_frame_deframer_core: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Driver tasks; each is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one byte, with random idle cycles first, and hold it until taken.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] ftr);
        send_byte(hdr);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            send_byte(frame_payload[i]);
        send_byte(ftr);
    endtask

    function automatic void set_point(int i, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        frame_payload[i * BYTES_PER_POINT + 0] = x[7:0];
        frame_payload[i * BYTES_PER_POINT + 1] = x[15:8];
        frame_payload[i * BYTES_PER_POINT + 2] = y[7:0];
        frame_payload[i * BYTES_PER_POINT + 3] = y[15:8];
        frame_payload[i * BYTES_PER_POINT + 4] = z[7:0];
        frame_payload[i * BYTES_PER_POINT + 5] = z[15:8];
    endfunction

    // Payload bytes: mostly random, sometimes the extremes or the markers.
    function automatic logic [BYTE_W-1:0] pick_payload_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return sb.hdr;
            3:       return sb.ftr;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames, some bad footers, noise and cut-off frames.
    task automatic send_random_traffic(input int nbytes);
        int start;
        int kind;
        int n;
        start = sb.bytes_in;
        while (sb.bytes_in - start < nbytes)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                for (int i = 0; i < PAYLOAD_LEN; i++)
                    frame_payload[i] = pick_payload_byte();
                if ($urandom_range(0, 99) < 85)
                    send_frame(sb.hdr, sb.ftr);
                else
                    send_frame(sb.hdr, BYTE_W'($urandom_range(0, 255)));
            end
            else if (kind < 90)
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // Cut-off frame; what follows is taken as its payload.
                send_byte(sb.hdr);
                n = $urandom_range(1, PAYLOAD_LEN - 1);
                repeat (n) send_byte(pick_payload_byte());
            end
        end
    endtask

    // Leave the block hunting, wait for all words, then write both registers.
    task automatic drain_and_configure(input logic [BYTE_W-1:0] hdr,
                                       input logic [BYTE_W-1:0] ftr);
        while (sb.in_frame)
            send_byte(pick_payload_byte());
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_HEADER;
        cfg_wr_data <= hdr;
        @(posedge clk);
        sb.write_reg(CFG_HEADER, hdr);
        @(negedge clk);
        cfg_index   <= CFG_FOOTER;
        cfg_wr_data <= ftr;
        @(posedge clk);
        sb.write_reg(CFG_FOOTER, ftr);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int idle_p, input int stall_p);
        idle_pct  = idle_p;
        stall_pct = stall_p;
        phases_run++;
        send_random_traffic(RANDOM_BYTES);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_HEADER;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        out_stall   = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: header and footer both zero.
        for (int i = 0; i < PAYLOAD_LEN; i++)
            frame_payload[i] = 8'h00;
        send_frame(8'h00, 8'h00);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            frame_payload[i] = 8'hFF;
        send_frame(8'h00, 8'h00);
        run_phase(0, 0);

        // Distinct markers: noise, extreme values, markers inside the payload,
        // a bad footer, and back-to-back frames that meet a busy output.
        drain_and_configure(8'hA5, 8'h5A);
        idle_pct  = 0;
        stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        set_point(0, 16'h8000, 16'h7FFF, 16'hFFFF);
        set_point(1, 16'h0000, 16'h0001, 16'hFFFE);
        set_point(2, 16'h7FFF, 16'h8000, 16'h0000);
        set_point(3, 16'h00FF, 16'hFF00, 16'h5AA5);
        send_frame(8'hA5, 8'h5A);
        set_point(0, 16'hA5A5, 16'h5A5A, 16'hA55A);
        set_point(1, 16'h5AA5, 16'hA5A5, 16'h5A5A);
        send_frame(8'hA5, 8'h5A);
        send_frame(8'hA5, 8'hA5);
        send_frame(8'hA5, 8'h5A);
        stall_pct = 63;
        send_frame(8'hA5, 8'h5A);
        send_frame(8'hA5, 8'h5A);

        drain_and_configure(8'hA5, 8'h5A);
        run_phase(63, 0);
        // Header equal to footer, both at the top of the range.
        drain_and_configure(8'hFF, 8'hFF);
        run_phase(0, 63);
        drain_and_configure(8'h00, 8'hFF);
        run_phase(28, 28);
        drain_and_configure(8'hFF, 8'h00);
        run_phase(63, 0);
        drain_and_configure(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        run_phase(0, 63);
        drain_and_configure(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        run_phase(28, 28);

        // Let every expected word out, then watch for stray ones.
        while (sb.in_frame)
            send_byte(pick_payload_byte());
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d bytes over %0d phases: %0d frames accepted, %0d dropped,",
                 sb.bytes_in, phases_run, sb.frames_ok, sb.frames_dropped);
        $display("%0d keypoint words checked, %0d mismatches.", sb.words_out, sb.errors);
        if (sb.errors == 0)
            $display("** keypoint_frame_deframer_core: PASSED **");
        else
            $display("** keypoint_frame_deframer_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/kfd_pkg.sv
hdl/kfd_frame_sync.sv
hdl/keypoint_frame_deframer_core.sv
tb/tb_keypoint_frame_deframer_core.sv
